[src/tdl_pkg.sv]
// ----------------------------------------------------------------------------
// tdl_pkg: shared constants and types for the trail detail level pipeline
// Holds the fixed-point format, the step counts of the iterative units and
// the types that travel between the pipeline stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tdl_pkg;

    // Coordinates carry this many fraction bits.
    localparam int COORD_FRAC_BITS = 8;

    // A segment is short when its squared length is below 1.0 in Q.2F.
    localparam logic [51:0] SHORT_LIM = 52'd1 << (2 * COORD_FRAC_BITS);

    // Step counts of the iterative units.
    localparam int RATIO_STEPS = 16;
    localparam int SQRT_STEPS  = 26;
    localparam int QUOT_STEPS  = 8;

    // Register stages from input word to the output stage.
    localparam int PIPE_DEPTH = 3 + RATIO_STEPS + 4 + SQRT_STEPS + 1 + RATIO_STEPS + 2
                                + QUOT_STEPS;

    // Unity in Q.16.
    localparam logic [16:0] Q16_ONE = 17'h10000;

    // Register reset values.
    localparam logic [22:0] PROFILE_RST  = 23'd25600;
    localparam logic [22:0] TRAILING_RST = 23'd2560;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        REG_PROFILE  = 1'b0,
        REG_TRAILING = 1'b1
    } t_reg_idx;

    // Where the closest point of the segment lies.
    typedef enum logic [1:0] {
        MODE_SHORT,
        MODE_TAIL,
        MODE_HEAD,
        MODE_MID
    } t_mode;

    typedef logic signed [24:0] t_diff;
    typedef t_diff [2:0]        t_vec3;
    typedef logic signed [25:0] t_err;
    typedef t_err [2:0]         t_evec3;

    // Side data carried beside the first ratio unit.
    typedef struct packed {
        t_mode       mode;
        t_vec3       v;
        t_vec3       c;
        t_vec3       h;
        logic [51:0] len2;
    } t_side1;

    // Side data carried beside the square root units.
    typedef struct packed {
        logic        endp;
        logic [51:0] an;
    } t_side2;

    // Side data carried beside the second ratio unit.
    typedef struct packed {
        logic        endp;
        logic [25:0] cam_dist;
    } t_side3;

endpackage

`default_nettype wire

[src/tdl_ratio.sv]
// ----------------------------------------------------------------------------
// tdl_ratio: pipelined Q.16 ratio
// Computes floor(num * 2^16 / den), saturated to 1.0 when num >= den, with
// one restoring division step per register stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tdl_ratio (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [51:0] i_num,
    input  logic [51:0] i_den,
    output logic [16:0] o_quo
);
    import tdl_pkg::*;

    logic [52:0] s_rem [RATIO_STEPS];
    logic [51:0] s_den [RATIO_STEPS];
    logic [15:0] s_quo [RATIO_STEPS];
    logic        s_sat [RATIO_STEPS];
    logic [52:0] n_rem [RATIO_STEPS];
    logic [51:0] n_den [RATIO_STEPS];
    logic [15:0] n_quo [RATIO_STEPS];
    logic        n_sat [RATIO_STEPS];
    logic [52:0] r_rem [RATIO_STEPS];
    logic [51:0] r_den [RATIO_STEPS];
    logic [15:0] r_quo [RATIO_STEPS];
    logic        r_sat [RATIO_STEPS];
    logic [52:0] w_sh;

    // One shift and conditional subtract per stage.
    always_comb begin
        s_rem[0] = {1'b0, i_num};
        s_den[0] = i_den;
        s_quo[0] = '0;
        s_sat[0] = (i_num >= i_den);
        for (int k = 1; k < RATIO_STEPS; k++) begin
            s_rem[k] = r_rem[k-1];
            s_den[k] = r_den[k-1];
            s_quo[k] = r_quo[k-1];
            s_sat[k] = r_sat[k-1];
        end
        for (int k = 0; k < RATIO_STEPS; k++) begin
            w_sh = {s_rem[k][51:0], 1'b0};
            if (w_sh >= {1'b0, s_den[k]}) begin
                n_rem[k] = w_sh - {1'b0, s_den[k]};
                n_quo[k] = {s_quo[k][14:0], 1'b1};
            end else begin
                n_rem[k] = w_sh;
                n_quo[k] = {s_quo[k][14:0], 1'b0};
            end
            n_den[k] = s_den[k];
            n_sat[k] = s_sat[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < RATIO_STEPS; k++) begin
                r_rem[k] <= n_rem[k];
                r_den[k] <= n_den[k];
                r_quo[k] <= n_quo[k];
                r_sat[k] <= n_sat[k];
            end
        end
    end

    assign o_quo = r_sat[RATIO_STEPS-1] ? Q16_ONE : {1'b0, r_quo[RATIO_STEPS-1]};

endmodule

`default_nettype wire

[src/tdl_sqrt.sv]
// ----------------------------------------------------------------------------
// tdl_sqrt: pipelined integer square root
// Computes floor(sqrt(x)) of a 52-bit value, one result bit per register
// stage, taking the radicand two bits at a time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tdl_sqrt (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [51:0] i_rad,
    output logic [25:0] o_root
);
    import tdl_pkg::*;

    logic [27:0] s_rem  [SQRT_STEPS];
    logic [25:0] s_root [SQRT_STEPS];
    logic [51:0] s_rad  [SQRT_STEPS];
    logic [27:0] n_rem  [SQRT_STEPS];
    logic [25:0] n_root [SQRT_STEPS];
    logic [51:0] n_rad  [SQRT_STEPS];
    logic [27:0] r_rem  [SQRT_STEPS];
    logic [25:0] r_root [SQRT_STEPS];
    logic [51:0] r_rad  [SQRT_STEPS];
    logic [27:0] w_sh;
    logic [27:0] w_trial;

    // Bring down the next bit pair and try the next root bit.
    always_comb begin
        s_rem[0]  = '0;
        s_root[0] = '0;
        s_rad[0]  = i_rad;
        for (int k = 1; k < SQRT_STEPS; k++) begin
            s_rem[k]  = r_rem[k-1];
            s_root[k] = r_root[k-1];
            s_rad[k]  = r_rad[k-1];
        end
        for (int k = 0; k < SQRT_STEPS; k++) begin
            w_sh    = {s_rem[k][25:0], s_rad[k][51:50]};
            w_trial = {s_root[k], 2'b01};
            if (w_sh >= w_trial) begin
                n_rem[k]  = w_sh - w_trial;
                n_root[k] = {s_root[k][24:0], 1'b1};
            end else begin
                n_rem[k]  = w_sh;
                n_root[k] = {s_root[k][24:0], 1'b0};
            end
            n_rad[k] = {s_rad[k][49:0], 2'b00};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < SQRT_STEPS; k++) begin
                r_rem[k]  <= n_rem[k];
                r_root[k] <= n_root[k];
                r_rad[k]  <= n_rad[k];
            end
        end
    end

    assign o_root = r_root[SQRT_STEPS-1];

endmodule

`default_nettype wire

[src/tdl_quot.sv]
// ----------------------------------------------------------------------------
// tdl_quot: pipelined detail quotient
// Computes floor(num / (dist * 2^16)) saturated to 255, one quotient bit per
// register stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tdl_quot (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [47:0] i_num,
    input  logic [25:0] i_dist,
    output logic [7:0]  o_level
);
    import tdl_pkg::*;

    logic [47:0] s_rem [QUOT_STEPS];
    logic [25:0] s_den [QUOT_STEPS];
    logic [7:0]  s_quo [QUOT_STEPS];
    logic        s_sat [QUOT_STEPS];
    logic [47:0] n_rem [QUOT_STEPS];
    logic [25:0] n_den [QUOT_STEPS];
    logic [7:0]  n_quo [QUOT_STEPS];
    logic        n_sat [QUOT_STEPS];
    logic [47:0] r_rem [QUOT_STEPS];
    logic [25:0] r_den [QUOT_STEPS];
    logic [7:0]  r_quo [QUOT_STEPS];
    logic        r_sat [QUOT_STEPS];
    logic [49:0] w_dsh;
    logic [49:0] w_diff;

    // Overflow when the quotient would reach 256; a zero distance lands here too.
    always_comb begin
        s_rem[0] = i_num;
        s_den[0] = i_dist;
        s_quo[0] = '0;
        s_sat[0] = ({2'b00, i_num} >= (50'(i_dist) << (16 + QUOT_STEPS)));
        for (int k = 1; k < QUOT_STEPS; k++) begin
            s_rem[k] = r_rem[k-1];
            s_den[k] = r_den[k-1];
            s_quo[k] = r_quo[k-1];
            s_sat[k] = r_sat[k-1];
        end
        for (int k = 0; k < QUOT_STEPS; k++) begin
            w_dsh  = 50'(s_den[k]) << (16 + QUOT_STEPS - 1 - k);
            w_diff = {2'b00, s_rem[k]} - w_dsh;
            if ({2'b00, s_rem[k]} >= w_dsh) begin
                n_rem[k] = w_diff[47:0];
                n_quo[k] = {s_quo[k][6:0], 1'b1};
            end else begin
                n_rem[k] = s_rem[k];
                n_quo[k] = {s_quo[k][6:0], 1'b0};
            end
            n_den[k] = s_den[k];
            n_sat[k] = s_sat[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < QUOT_STEPS; k++) begin
                r_rem[k] <= n_rem[k];
                r_den[k] <= n_den[k];
                r_quo[k] <= n_quo[k];
                r_sat[k] <= n_sat[k];
            end
        end
    end

    assign o_level = r_sat[QUOT_STEPS-1] ? 8'hFF : r_quo[QUOT_STEPS-1];

endmodule

`default_nettype wire

[src/trail_detail_level_top.sv]
// Throughput: one word per cycle while the skid stage is free; the depth is set
// by the two 16-step ratio units, the 26-step square root units and the 8-step
// quotient unit in series.
// An output register with a skid stage lets the pipeline run while a result waits.
// Reset is synchronous and active low; it empties the pipeline and restores
// both distance registers.
// ----------------------------------------------------------------------------
// trail_detail_level_top: trail detail level pipeline
// Finds the camera distance to the closest point of a trail segment, blends
// the two distance registers by the view angle and gives a 0..255 level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module trail_detail_level_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [23:0] i_cam_x,
    input  logic signed [23:0] i_cam_y,
    input  logic signed [23:0] i_cam_z,
    input  logic signed [23:0] i_head_x,
    input  logic signed [23:0] i_head_y,
    input  logic signed [23:0] i_head_z,
    input  logic signed [23:0] i_tail_x,
    input  logic signed [23:0] i_tail_y,
    input  logic signed [23:0] i_tail_z,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [7:0]         o_detail_level,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [0:0]         i_cfg_index,
    input  logic [22:0]        i_cfg_data
);
    import tdl_pkg::*;

    logic               en;
    logic               take;
    logic [7:0]         w_level;
    logic               r_vld [PIPE_DEPTH];
    logic [22:0]        r_profile;
    logic [22:0]        r_trailing;
    logic               r_out_vld;
    logic [7:0]         r_out_data;
    logic               r_skid_vld;
    logic [7:0]         r_skid_data;

    logic signed [23:0] w_cam  [3];
    logic signed [23:0] w_head [3];
    logic signed [23:0] w_tail [3];

    t_vec3              r1_v, r1_c, r1_h;
    logic signed [49:0] r2_vv [3];
    logic signed [49:0] r2_vc [3];
    t_vec3              r2_v, r2_c, r2_h;
    logic [51:0]        r3_len2;
    logic signed [51:0] r3_t;
    t_vec3              r3_v, r3_c, r3_h;
    t_side1             w_side1;
    logic [51:0]        w_rnum;
    t_side1             r_d1 [RATIO_STEPS];
    logic [16:0]        w_k16;

    logic [23:0]        w_mag [3];
    t_diff              w_abs [3];
    logic [40:0]        r4_prod [3];
    t_side1             r4_side;
    logic [40:0]        w_rnd [3];
    t_err               w_off [3];
    t_evec3             w_e;
    t_evec3             r5_e;
    t_vec3              r5_v;
    logic               r5_endp;
    logic [51:0]        r5_len2;
    logic signed [51:0] r6_ee [3];
    logic signed [51:0] r6_ve [3];
    logic               r6_endp;
    logic [51:0]        r6_len2;
    logic signed [51:0] w_n;
    logic [51:0]        r7_ee;
    logic [51:0]        r7_an;
    logic               r7_endp;
    logic [51:0]        r7_len2;
    t_side2             r_d2 [SQRT_STEPS];
    logic [25:0]        w_dist;
    logic [25:0]        w_lv;
    logic [51:0]        r8_dw;
    logic [51:0]        r8_an;
    logic               r8_endp;
    logic [25:0]        r8_dist;
    t_side3             r_d3 [RATIO_STEPS];
    logic [16:0]        w_q16;
    logic [16:0]        w_w16;
    logic [39:0]        r9_pp;
    logic [39:0]        r9_pt;
    logic [25:0]        r9_dist;
    logic [40:0]        w_blend;
    logic [48:0]        w_n255;
    logic [47:0]        r10_n;
    logic [25:0]        r10_dist;

    // The pipeline moves whenever the skid stage is free.
    assign en         = !r_skid_vld;
    assign o_in_ready = en;
    assign o_cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_profile  <= PROFILE_RST;
            r_trailing <= TRAILING_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_PROFILE:  r_profile  <= i_cfg_data;
                REG_TRAILING: r_trailing <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Valid bits travel with the words.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < PIPE_DEPTH; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= i_in_valid;
            for (int k = 1; k < PIPE_DEPTH; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    assign w_cam  = '{i_cam_x, i_cam_y, i_cam_z};
    assign w_head = '{i_head_x, i_head_y, i_head_z};
    assign w_tail = '{i_tail_x, i_tail_y, i_tail_z};

    // Stages 1 to 3: segment vector, camera offsets, length and projection.
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r1_v[i] <= 25'(w_head[i]) - 25'(w_tail[i]);
                r1_c[i] <= 25'(w_cam[i]) - 25'(w_tail[i]);
                r1_h[i] <= 25'(w_head[i]) - 25'(w_cam[i]);
                r2_vv[i] <= r1_v[i] * r1_v[i];
                r2_vc[i] <= r1_v[i] * r1_c[i];
            end
            r2_v    <= r1_v;
            r2_c    <= r1_c;
            r2_h    <= r1_h;
            r3_len2 <= 52'(r2_vv[0]) + 52'(r2_vv[1]) + 52'(r2_vv[2]);
            r3_t    <= 52'(r2_vc[0]) + 52'(r2_vc[1]) + 52'(r2_vc[2]);
            r3_v    <= r2_v;
            r3_c    <= r2_c;
            r3_h    <= r2_h;
        end
    end

    // Classify where the closest point lies.
    always_comb begin
        w_side1.v    = r3_v;
        w_side1.c    = r3_c;
        w_side1.h    = r3_h;
        w_side1.len2 = r3_len2;
        if (r3_len2 < SHORT_LIM) begin
            w_side1.mode = MODE_SHORT;
        end else if (r3_t[51]) begin
            w_side1.mode = MODE_TAIL;
        end else if ($unsigned(r3_t) > r3_len2) begin
            w_side1.mode = MODE_HEAD;
        end else begin
            w_side1.mode = MODE_MID;
        end
        w_rnum = r3_t[51] ? '0 : $unsigned(r3_t);
    end

    // Position of the closest interior point along the segment.
    tdl_ratio u_pos (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (w_rnum),
        .i_den (r3_len2),
        .o_quo (w_k16)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d1[0] <= w_side1;
            for (int k = 1; k < RATIO_STEPS; k++) begin
                r_d1[k] <= r_d1[k-1];
            end
        end
    end

    // Magnitudes of the segment vector along each axis.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_abs[i] = r_d1[RATIO_STEPS-1].v[i][24] ? -r_d1[RATIO_STEPS-1].v[i]
                                                    : r_d1[RATIO_STEPS-1].v[i];
            w_mag[i] = w_abs[i][23:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r4_prod[i] <= 41'(w_k16) * 41'(w_mag[i]);
            end
            r4_side <= r_d1[RATIO_STEPS-1];
        end
    end

    // Error vector from the camera to the closest point.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_rnd[i] = r4_prod[i] + 41'd32768;
            w_off[i] = r4_side.v[i][24] ? -{1'b0, w_rnd[i][40:16]} : {1'b0, w_rnd[i][40:16]};
            case (r4_side.mode)
                MODE_TAIL: w_e[i] = -26'(r4_side.c[i]);
                MODE_MID:  w_e[i] = w_off[i] - 26'(r4_side.c[i]);
                default:   w_e[i] = 26'(r4_side.h[i]);
            endcase
        end
    end

    // Squared distance and the projection of the error onto the segment.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_e    <= w_e;
            r5_v    <= r4_side.v;
            r5_endp <= (r4_side.mode == MODE_TAIL) || (r4_side.mode == MODE_HEAD);
            r5_len2 <= r4_side.len2;
            for (int i = 0; i < 3; i++) begin
                r6_ee[i] <= r5_e[i] * r5_e[i];
                r6_ve[i] <= r5_v[i] * r5_e[i];
            end
            r6_endp <= r5_endp;
            r6_len2 <= r5_len2;
            r7_ee   <= $unsigned(r6_ee[0] + r6_ee[1] + r6_ee[2]);
            r7_an   <= w_n[51] ? $unsigned(-w_n) : $unsigned(w_n);
            r7_endp <= r6_endp;
            r7_len2 <= r6_len2;
        end
    end

    assign w_n = r6_ve[0] + r6_ve[1] + r6_ve[2];

    // Camera distance and segment length.
    tdl_sqrt u_dist (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rad  (r7_ee),
        .o_root (w_dist)
    );

    tdl_sqrt u_len (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rad  (r7_len2),
        .o_root (w_lv)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d2[0] <= '{endp: r7_endp, an: r7_an};
            for (int k = 1; k < SQRT_STEPS; k++) begin
                r_d2[k] <= r_d2[k-1];
            end
            r8_dw   <= 52'(w_lv) * 52'(w_dist);
            r8_an   <= r_d2[SQRT_STEPS-1].an;
            r8_endp <= r_d2[SQRT_STEPS-1].endp;
            r8_dist <= w_dist;
        end
    end

    // Blend weight from the cosine between trail and view direction.
    tdl_ratio u_cos (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r8_an),
        .i_den (r8_dw),
        .o_quo (w_q16)
    );

    assign w_w16 = r_d3[RATIO_STEPS-1].endp ? w_q16 : '0;

    // Blend the two distances and scale by 255.
    assign w_blend = 41'(r9_pp) + 41'(r9_pt);
    assign w_n255  = {w_blend, 8'b0} - {8'b0, w_blend};

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d3[0] <= '{endp: r8_endp, cam_dist: r8_dist};
            for (int k = 1; k < RATIO_STEPS; k++) begin
                r_d3[k] <= r_d3[k-1];
            end
            r9_pp    <= 40'(Q16_ONE - w_w16) * 40'(r_profile);
            r9_pt    <= 40'(w_w16) * 40'(r_trailing);
            r9_dist  <= r_d3[RATIO_STEPS-1].cam_dist;
            r10_n    <= w_n255[47:0];
            r10_dist <= r9_dist;
        end
    end

    // Final quotient; a zero distance saturates to full detail.
    tdl_quot u_quot (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_num   (r10_n),
        .i_dist  (r10_dist),
        .o_level (w_level)
    );

    assign take = en && r_vld[PIPE_DEPTH-1];

    // Output register with skid stage: control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (!r_out_vld || i_out_ready) begin
            r_out_vld  <= r_skid_vld || take;
            r_skid_vld <= 1'b0;
        end else if (take) begin
            r_skid_vld <= 1'b1;
        end
    end

    // Output register with skid stage: data.
    always_ff @(posedge i_clk) begin
        if (!r_out_vld || i_out_ready) begin
            r_out_data <= r_skid_vld ? r_skid_data : w_level;
        end else if (take) begin
            r_skid_data <= w_level;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_detail_level = r_out_data;

endmodule

`default_nettype wire

[src/tdl_checker.sv]
// ----------------------------------------------------------------------------
// tdl_checker: port checks for the trail detail level block
// Watches the ports of the top level for reset, output hold and words that
// appear without an input behind them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tdl_checker (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_in_valid,
    input  wire        o_in_ready,
    input  wire        o_out_valid,
    input  wire        i_out_ready,
    input  wire [7:0]  o_detail_level
);
    logic [7:0] r_cnt;
    logic [7:0] n_cnt;

    // Words accepted but not yet delivered.
    always_comb begin
        n_cnt = r_cnt;
        if (i_in_valid && o_in_ready) begin
            n_cnt = n_cnt + 8'd1;
        end
        if (o_out_valid && i_out_ready) begin
            n_cnt = n_cnt - 8'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output word valid right after reset");

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output word dropped before it was taken");

    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_detail_level))
        else $error("stalled output word changed");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 8'd0) |-> !o_out_valid)
        else $error("output word without an input word behind it");

endmodule

bind trail_detail_level_top tdl_checker u_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_detail_level (o_detail_level)
);

`default_nettype wire
